// File: sv/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// shared codes and controller/datapath handshake types for the deque block
// ----------------------------------------------------------------------------
package dq_pkg;

  typedef logic [2:0] action_t;
  typedef logic [1:0] status_t;

  localparam action_t ACT_PUSH_BACK  = 3'd0;
  localparam action_t ACT_PUSH_FRONT = 3'd1;
  localparam action_t ACT_POP_BACK   = 3'd2;
  localparam action_t ACT_POP_FRONT  = 3'd3;
  localparam action_t ACT_PEEK_FRONT = 3'd4;
  localparam action_t ACT_PEEK_BACK  = 3'd5;
  localparam action_t ACT_CLEAR      = 3'd6;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the request word
    logic exec;     // do the storage access and pointer update
    logic finish;   // load read data into the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_read;  // latched request reads storage
  } stat_t;

endpackage

// File: sv/dq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_req_if / dq_rsp_if
// valid/ready channels for deque requests and results
// ----------------------------------------------------------------------------
interface dq_req_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  dq_pkg::action_t       action;
  logic [DATA_WIDTH-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface dq_rsp_if #(
  parameter int DATA_WIDTH  = 32,
  parameter int COUNT_WIDTH = 5
);
  logic                   valid;
  logic                   ready;
  logic [DATA_WIDTH-1:0]  data_out;
  dq_pkg::status_t        status;
  logic [COUNT_WIDTH-1:0] count;

  modport source (output valid, output data_out, output status, output count, input ready);
  modport sink   (input valid, input data_out, input status, input count, output ready);
endinterface

// File: sv/dq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ram
// single-port ram with registered read
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/dq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl
// request sequencer: accept, execute, optional read wait, result hand-off
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  dq_pkg::stat_t stat,
  output dq_pkg::cmd_t  cmd
);
  import dq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;

  // a new word is taken while idle, once the result register is free or being emptied
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.need_read) begin
          state_next = S_READ;
        end else begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_READ: begin
        cmd.finish     = 1'b1;
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: sv/dq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_datapath
// ring pointers, storage ram and result register
// ----------------------------------------------------------------------------
module dq_datapath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dq_pkg::cmd_t                 cmd,
  output dq_pkg::stat_t                stat,
  input  dq_pkg::action_t              in_action,
  input  logic [DATA_WIDTH-1:0]        in_value,
  output logic [DATA_WIDTH-1:0]        out_data,
  output dq_pkg::status_t              out_status,
  output logic [$clog2(DEPTH+1)-1:0]   out_count
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  logic [AW-1:0]         head;
  logic [AW-1:0]         head_next;
  logic [CW-1:0]         fill;
  logic [CW-1:0]         fill_next;
  action_t               req_action;
  logic [DATA_WIDTH-1:0] req_value;

  logic                  full;
  logic                  empty;
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  status_t               status_next;
  logic                  need_read;

  logic [AW-1:0] pos_tail;   // slot after the back element
  logic [AW-1:0] pos_back;   // back element
  logic [AW-1:0] pos_second; // slot after the head
  logic [AW-1:0] pos_prev;   // slot before the head

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(base) + (CW + 1)'(off);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[AW-1:0];
  endfunction

  assign full       = (fill == DEPTH_C);
  assign empty      = (fill == '0);
  assign pos_tail   = ring_add(head, fill);
  assign pos_back   = ring_add(head, fill - CW'(1));
  assign pos_second = ring_add(head, CW'(1));
  assign pos_prev   = (head == '0) ? LAST_A : head - AW'(1);

  always_comb begin
    head_next   = head;
    fill_next   = fill;
    ram_we      = 1'b0;
    ram_addr    = head;
    status_next = ST_OK;
    need_read   = 1'b0;
    case (req_action)
      ACT_PUSH_BACK: begin
        ram_addr = pos_tail;
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ram_we    = 1'b1;
          fill_next = fill + CW'(1);
        end
      end
      ACT_PUSH_FRONT: begin
        ram_addr = pos_prev;
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ram_we    = 1'b1;
          head_next = pos_prev;
          fill_next = fill + CW'(1);
        end
      end
      ACT_POP_BACK, ACT_PEEK_BACK: begin
        ram_addr = pos_back;
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          need_read = 1'b1;
          if (req_action == ACT_POP_BACK) begin
            fill_next = fill - CW'(1);
          end
        end
      end
      ACT_POP_FRONT, ACT_PEEK_FRONT: begin
        ram_addr = head;
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          need_read = 1'b1;
          if (req_action == ACT_POP_FRONT) begin
            head_next = pos_second;
            fill_next = fill - CW'(1);
          end
        end
      end
      ACT_CLEAR: begin
        head_next = '0;
        fill_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign stat.need_read = need_read;

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.exec && ram_we),
    .addr  (ram_addr),
    .wdata (req_value),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (cmd.exec) begin
      head <= head_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_action <= in_action;
      req_value  <= in_value;
    end
    if (cmd.exec) begin
      out_data   <= '0;
      out_status <= status_next;
      out_count  <= fill_next;
    end
    if (cmd.finish) begin
      out_data <= ram_rdata;
    end
  end

endmodule

// File: sv/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// fixed-capacity deque kept as a ring buffer in a single-port ram
// ----------------------------------------------------------------------------
// Each request word carries an action (push back, push front, pop back, pop
// front, peek front, peek back, clear) and a value used only by pushes, and
// produces exactly one result word: the popped or peeked element (zero
// otherwise), a status (ok, empty on pop/peek, full on push) and the number
// of elements held afterwards. A request is accepted, then executed with the
// ram access and pointer update; one that reads storage (pop or peek) then
// waits for the registered ram read, while pushes, clear, errors and the
// unused action code do not. The single ram port and the one request in
// flight set this sequence. The result sits in an output register; the next
// request is accepted in the same cycle the previous result is taken. No
// clearing pass is needed after reset: only occupied slots are ever read,
// and each was written first.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  dq_req_if.sink   req,
  dq_rsp_if.source rsp
);
  import dq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing: accept -> exec -> (read wait) -> result valid
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // head pointer, fill count, storage and the result register
  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_action  (req.action),
    .in_value   (req.value),
    .out_data   (rsp.data_out),
    .out_status (rsp.status),
    .out_count  (rsp.count)
  );

endmodule

// File: sim/double_ended_queue_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_chk
// watches the request and result channels of the deque and scores each word
// ----------------------------------------------------------------------------
// Every accepted request word is run through a local copy of the deque (ring,
// head, fill) and the resulting word is queued. Every accepted result word is
// compared field by field against the oldest queued word. The number of
// mismatches and the number of words still awaited go back to the top.
// ----------------------------------------------------------------------------
module double_ended_queue_chk #(
  parameter int DEPTH       = 16,
  parameter int DATA_WIDTH  = 32,
  parameter int COUNT_WIDTH = 5
) (
  input  logic clk,
  input  logic rst,
  dq_req_if    req,
  dq_rsp_if    rsp,
  output int   fail_count,
  output int   pending
);
  import dq_pkg::*;

  typedef struct packed {
    logic [DATA_WIDTH-1:0]  data;
    status_t                status;
    logic [COUNT_WIDTH-1:0] count;
  } deque_word_t;

  logic [DATA_WIDTH-1:0] slots [DEPTH];
  int                    head;
  int                    fill;
  deque_word_t           awaited_words [$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  // applies one request to the local deque and returns the result word
  function automatic deque_word_t deque_apply(action_t act, logic [DATA_WIDTH-1:0] val);
    deque_word_t w;
    w.data   = '0;
    w.status = ST_OK;
    case (act)
      ACT_PUSH_BACK: begin
        if (fill == DEPTH) begin
          w.status = ST_FULL;
        end else begin
          slots[(head + fill) % DEPTH] = val;
          fill++;
        end
      end
      ACT_PUSH_FRONT: begin
        if (fill == DEPTH) begin
          w.status = ST_FULL;
        end else begin
          head = (head + DEPTH - 1) % DEPTH;
          slots[head] = val;
          fill++;
        end
      end
      ACT_POP_BACK, ACT_PEEK_BACK: begin
        if (fill == 0) begin
          w.status = ST_EMPTY;
        end else begin
          w.data = slots[(head + fill - 1) % DEPTH];
          if (act == ACT_POP_BACK) fill--;
        end
      end
      ACT_POP_FRONT, ACT_PEEK_FRONT: begin
        if (fill == 0) begin
          w.status = ST_EMPTY;
        end else begin
          w.data = slots[head];
          if (act == ACT_POP_FRONT) begin
            head = (head + 1) % DEPTH;
            fill--;
          end
        end
      end
      ACT_CLEAR: begin
        fill = 0;
        head = 0;
      end
      default: ;  // unused code does nothing
    endcase
    w.count = COUNT_WIDTH'(fill);
    return w;
  endfunction

  always @(posedge clk) begin
    deque_word_t want;
    if (rst) begin
      awaited_words.delete();
      head = 0;
      fill = 0;
    end else begin
      // results first: a result word always belongs to an earlier request
      if (rsp.valid && rsp.ready) begin
        if (awaited_words.size() == 0) begin
          report_mismatch("unexpected result word", 64'(rsp.data_out), '0);
        end else begin
          want = awaited_words.pop_front();
          if (rsp.data_out !== want.data)
            report_mismatch("data_out", 64'(rsp.data_out), 64'(want.data));
          if (rsp.status !== want.status)
            report_mismatch("status", 64'(rsp.status), 64'(want.status));
          if (rsp.count !== want.count)
            report_mismatch("count", 64'(rsp.count), 64'(want.count));
        end
      end
      if (req.valid && req.ready)
        awaited_words.push_back(deque_apply(req.action, req.value));
    end
    pending <= awaited_words.size();
  end

endmodule

// File: sim/double_ended_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// stimulus and verdict for the fixed-capacity deque
// ----------------------------------------------------------------------------
// A short directed run covers empty and full errors, both push sides, every
// pop and peek, clear and the unused action code. A random run follows with
// fill, drain and balanced stretches so the deque keeps hitting both empty and
// full and its head wraps in both directions. The scoring lives in the
// checker beside the block; this module only drives and decides.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int RAND_WORDS  = 1600;
  localparam int LONG_HOLD   = 300;        // length of the one long hold-off on the result side
  localparam int TIMEOUT_NS  = 5_000_000;  // far beyond the slowest legal run

  // the block treats the spare action code as a no-op
  localparam action_t ACT_NOP = 3'd7;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;

  // result side controls, set by the request side
  bit   rx_hold;   // ask for one long hold-off
  bit   rx_quiet;  // no more stalls on the result side
  bit   tx_quiet;  // no more gaps on the request side

  dq_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_ch ();
  dq_rsp_if #(.DATA_WIDTH(DATA_WIDTH), .COUNT_WIDTH(5)) rsp_ch ();

  double_ended_queue #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  double_ended_queue_chk #(
    .DEPTH       (DEPTH),
    .DATA_WIDTH  (DATA_WIDTH),
    .COUNT_WIDTH (5)
  ) chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("double_ended_queue_tb: FAIL");
    $finish;
  end

  // offer one request word and hold it until the block takes it; valid stays
  // high on return so back-to-back words go out with no bubble
  task automatic send_word(input action_t act, input logic [DATA_WIDTH-1:0] val);
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.value  <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // drop valid for the requested gap, with junk on the payload
  task automatic tx_gap(input int cycles);
    req_ch.valid  <= 1'b0;
    req_ch.action <= action_t'($urandom_range(0, 7));
    req_ch.value  <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  // wait until every result word in flight has come back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // result side: random ready with stall bursts, one long hold-off on request
  initial begin : result_side
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold) begin
        // long hold-off: request side keeps offering and gets stalled
        rx_hold = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (rx_quiet || $urandom_range(0, 2) != 0) begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  // request side
  initial begin : request_side
    int                    n;
    int                    r;
    int                    lean;
    int                    push_pct;
    bit                    calm;
    action_t               act;
    logic [DATA_WIDTH-1:0] val;
    int                    waited;

    rst           <= 1'b1;
    req_ch.valid  <= 1'b0;
    req_ch.action <= ACT_NOP;
    req_ch.value  <= '0;
    rx_hold  = 1'b0;
    rx_quiet = 1'b0;
    tx_quiet = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // pops and peeks on an empty deque report empty and change nothing
    send_word(ACT_POP_BACK,   32'hFFFF_FFFF);
    send_word(ACT_POP_FRONT,  32'h0);
    send_word(ACT_PEEK_FRONT, 32'h0);
    send_word(ACT_PEEK_BACK,  32'hFFFF_FFFF);
    send_word(ACT_NOP,        32'hA5A5_A5A5);
    // fill to capacity from both ends; the first front push wraps the head
    for (n = 0; n < DEPTH; n++) begin
      if (n == 0)      val = 32'h0;
      else if (n == 1) val = 32'hFFFF_FFFF;
      else             val = $urandom;
      send_word(n[0] ? ACT_PUSH_BACK : ACT_PUSH_FRONT, val);
    end
    // pushes on a full deque are dropped
    send_word(ACT_PUSH_BACK,  32'h1234_5678);
    send_word(ACT_PUSH_FRONT, 32'h8765_4321);
    send_word(ACT_POP_BACK,   32'h0);
    send_word(ACT_POP_FRONT,  32'h0);
    send_word(ACT_PEEK_FRONT, 32'h0);
    send_word(ACT_PEEK_BACK,  32'h0);
    send_word(ACT_CLEAR,      32'h0);

    // --- random part ---
    lean = 0;
    calm = 1'b0;
    for (n = 0; n < RAND_WORDS; n++) begin
      // every 40 words pick fill, drain or balanced, and whether gaps occur
      if (n % 40 == 0) begin
        lean = $urandom_range(0, 2);
        calm = ($urandom_range(0, 3) == 0);
      end
      if (n == 500) rx_hold = 1'b1;
      if (n == 1000) drain_results();
      // last stretch runs flat out on both sides
      if (n == RAND_WORDS - 200) begin
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
      end

      case (lean)
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      r = $urandom_range(0, 99);
      if (r < 1)
        act = ACT_CLEAR;
      else if (r < 2)
        act = ACT_NOP;
      else if (r < 12)
        act = $urandom_range(0, 1) ? ACT_PEEK_FRONT : ACT_PEEK_BACK;
      else if ($urandom_range(0, 99) < push_pct)
        act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
      else
        act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;

      // mostly random values, with corners mixed in
      case ($urandom_range(0, 7))
        0:       val = '0;
        1:       val = '1;
        2:       val = 32'h1 << $urandom_range(0, 31);
        default: val = $urandom;
      endcase

      send_word(act, val);
      if (!tx_quiet && !calm && $urandom_range(0, 5) == 0)
        tx_gap($urandom_range(1, 13));
    end

    // --- wind down ---
    req_ch.valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    // keep the clock running to catch any stray result word
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("double_ended_queue_tb: PASS");
    end else begin
      $display("double_ended_queue_tb: FAIL");
    end
    $finish;
  end

endmodule
